/* rtl/assert_macros.svh */
// Assertion macros shared by the list control and datapath modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* rtl/bol_pkg.sv */
// Shared types and constants of the bounded ordered list.
package bol_pkg;

  localparam int DEPTH  = 32;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int DATA_W = 64;
  localparam int ACT_W  = 3;
  localparam int FLD_W  = 6;

  localparam logic [1:0] REG_CAPACITY = 2'd0;

  typedef enum logic [ACT_W-1:0] {
    ACT_CLEAR  = 3'd0,
    ACT_APPEND = 3'd1,
    ACT_INSERT = 3'd2,
    ACT_ERASE  = 3'd3,
    ACT_READ   = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic load;
    logic exec;
  } bol_cmd_t;

endpackage

/* rtl/bol_ctrl.sv */
// Control state machine: takes a request, runs it, then presents the result.
`include "assert_macros.svh"
module bol_ctrl import bol_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output bol_cmd_t cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = ST_RESP;
      end
      ST_RESP: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  `ASSERT_IMPLIES(a_no_overlap, clk, rst, in_ready, !out_valid)
  `ASSERT_NEXT(a_load_then_exec, clk, rst, cmd.load, cmd.exec)
  `ASSERT_NEXT(a_exec_then_resp, clk, rst, cmd.exec, out_valid)

endmodule

/* rtl/bol_dp.sv */
// Datapath: entry cells with neighbour shifting, fill count and result registers.
`include "assert_macros.svh"
module bol_dp import bol_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  bol_cmd_t          cmd,
  input  logic [ACT_W-1:0]  action,
  input  logic [FLD_W-1:0]  index,
  input  logic [DATA_W-1:0] value,
  input  logic [FLD_W-1:0]  capacity,
  output logic              ok,
  output logic [DATA_W-1:0] read_data,
  output logic [FLD_W-1:0]  count,
  output logic              is_empty
);

  logic [ACT_W-1:0]  act;
  logic [FLD_W-1:0]  idx;
  logic [DATA_W-1:0] val;
  logic [CNT_W-1:0]  fill;
  logic [CNT_W-1:0]  fill_next;
  logic [DATA_W-1:0] entries [DEPTH];

  logic [CNT_W-1:0] lim;
  logic             has_room;
  logic             idx_in;
  logic             idx_le;
  logic             do_append;
  logic             do_insert;
  logic             do_erase;
  logic             do_read;
  logic             ok_c;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act <= action;
      idx <= index;
      val <= value;
    end
  end

  always_comb begin
    lim = (capacity > FLD_W'(DEPTH)) ? CNT_W'(DEPTH) : CNT_W'(capacity);
  end

  assign has_room = fill < lim;
  assign idx_in   = CNT_W'(idx) < fill;
  assign idx_le   = CNT_W'(idx) <= fill;

  always_comb begin
    do_append = 1'b0;
    do_insert = 1'b0;
    do_erase  = 1'b0;
    do_read   = 1'b0;
    ok_c      = 1'b0;
    fill_next = fill;
    unique case (act)
      ACT_CLEAR: begin
        ok_c      = 1'b1;
        fill_next = '0;
      end
      ACT_APPEND: begin
        do_append = has_room;
        ok_c      = has_room;
        if (has_room) fill_next = fill + 1'b1;
      end
      ACT_INSERT: begin
        do_insert = has_room && idx_le;
        ok_c      = do_insert;
        if (do_insert) fill_next = fill + 1'b1;
      end
      ACT_ERASE: begin
        do_erase = idx_in;
        ok_c     = idx_in;
        if (idx_in) fill_next = fill - 1'b1;
      end
      ACT_READ: begin
        do_read = idx_in;
        ok_c    = idx_in;
      end
      default: ok_c = 1'b0;
    endcase
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_W-1:0] below;
    logic [DATA_W-1:0] above;
    if (i == 0) begin : g_first
      assign below = entries[i];
    end else begin : g_mid
      assign below = entries[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign above = entries[i];
    end else begin : g_up
      assign above = entries[i+1];
    end
    always_ff @(posedge clk) begin
      if (cmd.exec) begin
        if (do_append && (CNT_W'(i) == fill)) begin
          entries[i] <= val;
        end else if (do_insert && (FLD_W'(i) == idx)) begin
          entries[i] <= val;
        end else if (do_insert && (FLD_W'(i) > idx)) begin
          entries[i] <= below;
        end else if (do_erase && (FLD_W'(i) >= idx)) begin
          entries[i] <= above;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (cmd.exec) begin
      fill <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      ok        <= ok_c;
      read_data <= do_read ? entries[idx[IDX_W-1:0]] : '0;
      count     <= FLD_W'(fill_next);
      is_empty  <= (fill_next == '0);
    end
  end

  `ASSERT_IMPLIES(a_fill_bound, clk, rst, 1'b1, fill <= CNT_W'(DEPTH))
  `ASSERT_NEXT(a_erase_shrinks, clk, rst, cmd.exec && do_erase, fill == $past(fill) - 1'b1)
  `ASSERT_NEXT(a_grow_room, clk, rst, cmd.exec && (do_append || do_insert),
               fill == $past(fill) + 1'b1)

endmodule

/* rtl/bounded_ordered_list.sv */
// Bounded ordered list: top level with the capacity register and the request channels.
// Sequence: a request is taken in ST_IDLE, executed in ST_EXEC, and its registered result
// is presented in ST_RESP; a new request is taken only after that result is accepted.
// The three-state control sequence sets this order; each list action is done in ST_EXEC.
// Reset empties the list and sets capacity to 32; stored words are not cleared.
module bounded_ordered_list import bol_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [79:0] s_tdata,   // action[2:0], index[8:3], value[72:9], zero[79:73]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // ok[0], read_data[64:1], count[70:65], is_empty[71]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [FLD_W-1:0]  capacity;
  bol_cmd_t          cmd;
  logic              ok;
  logic [DATA_W-1:0] read_data;
  logic [FLD_W-1:0]  count;
  logic              is_empty;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= FLD_W'(DEPTH);
    end else if (psel && penable && pwrite && pready && (paddr == REG_CAPACITY)) begin
      capacity <= pwdata[FLD_W-1:0];
    end
  end

  assign prdata = (paddr == REG_CAPACITY) ? {{(32-FLD_W){1'b0}}, capacity} : '0;

  bol_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .cmd       (cmd)
  );

  bol_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .action    (s_tdata[2:0]),
    .index     (s_tdata[8:3]),
    .value     (s_tdata[72:9]),
    .capacity  (capacity),
    .ok        (ok),
    .read_data (read_data),
    .count     (count),
    .is_empty  (is_empty)
  );

  assign m_tdata = {is_empty, count, read_data, ok};

endmodule

/* tb/list_check_pkg.sv */
// Request tracker and result checker for the bounded ordered list testbench.
package list_check_pkg;
  import bol_pkg::*;

  typedef struct packed {
    logic              is_empty;
    logic [CNT_W-1:0]  count;
    logic [DATA_W-1:0] read_data;
    logic              ok;
  } list_result_t;

  class list_scoreboard;
    logic [DATA_W-1:0] words [DEPTH];
    int unsigned       fill;
    logic [FLD_W-1:0]  capacity;
    list_result_t      expected_results [$];
    int unsigned       mismatches;

    function new();
      fill       = 0;
      capacity   = FLD_W'(32);
      mismatches = 0;
    endfunction

    function void set_capacity(logic [FLD_W-1:0] cap);
      capacity = cap;
    endfunction

    task report(string what, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
      $display("[%0t] mismatch in %s: got %0h, expected %0h", $time, what, got, want);
      mismatches++;
    endtask

    function void note_request(logic [ACT_W-1:0] act, logic [FLD_W-1:0] idx,
                               logic [DATA_W-1:0] val);
      list_result_t r;
      int unsigned  lim;
      int unsigned  pos;
      r   = '0;
      lim = (capacity > DEPTH) ? DEPTH : capacity;
      case (act)
        ACT_CLEAR: begin
          fill = 0;
          r.ok = 1'b1;
        end
        ACT_APPEND: begin
          if (fill < lim) begin
            words[fill] = val;
            fill++;
            r.ok = 1'b1;
          end
        end
        ACT_INSERT: begin
          if (idx <= fill && fill < lim) begin
            for (pos = fill; pos > idx; pos--) words[pos] = words[pos-1];
            words[idx] = val;
            fill++;
            r.ok = 1'b1;
          end
        end
        ACT_ERASE: begin
          if (idx < fill) begin
            for (pos = idx; pos + 1 < fill; pos++) words[pos] = words[pos+1];
            fill--;
            r.ok = 1'b1;
          end
        end
        ACT_READ: begin
          if (idx < fill) begin
            r.read_data = words[idx];
            r.ok        = 1'b1;
          end
        end
        default: begin
        end
      endcase
      r.count    = CNT_W'(fill);
      r.is_empty = (fill == 0);
      expected_results.push_back(r);
    endfunction

    task check_result(logic [$bits(list_result_t)-1:0] raw);
      list_result_t got;
      list_result_t want;
      got = raw;
      if (expected_results.size() == 0) begin
        report("result with no request outstanding", raw[DATA_W-1:0], '0);
      end else begin
        want = expected_results.pop_front();
        if (got.ok !== want.ok) report("ok", got.ok, want.ok);
        if (got.read_data !== want.read_data) report("read_data", got.read_data, want.read_data);
        if (got.count !== want.count) report("count", got.count, want.count);
        if (got.is_empty !== want.is_empty) report("is_empty", got.is_empty, want.is_empty);
      end
    endtask
  endclass

endpackage

/* tb/tb_top.sv */
// Top-level testbench of the bounded ordered list: stimulus, handshakes and final verdict.
module tb_top import bol_pkg::*, list_check_pkg::*;;

  localparam logic [ACT_W-1:0] ACT_BAD_FIRST  = 3'd5;
  localparam logic [ACT_W-1:0] ACT_BAD_LAST   = 3'd7;
  localparam int unsigned      CYCLE_LIMIT    = 400000;
  localparam int               RESULT_LATENCY = 3;
  localparam int               PHASE_ITEMS    = 133;
  localparam int               LONG_HOLD      = 80;

  logic        clk;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [79:0] s_tdata  = '0;   // action[2:0], index[8:3], value[72:9], zero[79:73]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [71:0] m_tdata;         // ok[0], read_data[64:1], count[70:65], is_empty[71]
  logic        psel     = 1'b0;
  logic        penable  = 1'b0;
  logic        pwrite   = 1'b0;
  logic [1:0]  paddr    = '0;
  logic [31:0] pwdata   = '0;
  logic [31:0] prdata;
  logic        pready;

  list_scoreboard tracker = new();
  bit             calm          = 1'b0;
  bit             long_hold_req = 1'b0;
  int unsigned    cycle_count   = 0;

  bounded_ordered_list dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : result_sink
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left  = 0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) tracker.check_result(m_tdata);
      if (long_hold_req) begin
        hold_left     = LONG_HOLD;
        long_hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 13) - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  task automatic send_request(input logic [ACT_W-1:0] act, input logic [FLD_W-1:0] idx,
                              input logic [DATA_W-1:0] val);
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {7'd0, val, idx, act};
    do @(posedge clk); while (!s_tready);
    tracker.note_request(act, idx, val);
  endtask

  task automatic drain_requests();
    s_tvalid <= 1'b0;
    while (tracker.expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic apb_write(input logic [1:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    tracker.set_capacity(data[FLD_W-1:0]);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apb_check(input logic [1:0] addr);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== {26'd0, tracker.capacity}) begin
      tracker.report("capacity readback", prdata, {26'd0, tracker.capacity});
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_request();
    int unsigned       roll;
    int unsigned       held;
    logic [ACT_W-1:0]  act;
    logic [FLD_W-1:0]  idx;
    logic [DATA_W-1:0] val;
    held = tracker.fill;
    roll = $urandom_range(0, 99);
    val  = {$urandom, $urandom};
    if ($urandom_range(0, 15) == 0) val = $urandom_range(0, 1) ? '1 : '0;
    idx = FLD_W'($urandom_range(0, 63));
    if (roll < 35) begin
      act = ACT_APPEND;
    end else if (roll < 55) begin
      act = ACT_INSERT;
      if ($urandom_range(0, 4) != 0) idx = FLD_W'($urandom_range(0, held));
    end else if (roll < 75) begin
      act = ACT_ERASE;
      if (held > 0 && $urandom_range(0, 4) != 0) idx = FLD_W'($urandom_range(0, held - 1));
    end else if (roll < 95) begin
      act = ACT_READ;
      if (held > 0 && $urandom_range(0, 4) != 0) idx = FLD_W'($urandom_range(0, held - 1));
    end else if (roll < 97) begin
      act = ACT_CLEAR;
    end else begin
      act = ACT_W'($urandom_range(ACT_BAD_FIRST, ACT_BAD_LAST));
    end
    send_request(act, idx, val);
  endtask

  initial begin : stimulus
    int caps [10];
    int phase;
    int n;
    caps = '{1, 2, 63, 0, 5, 40, 17, 32, 3, 32};
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    apb_check(REG_CAPACITY);

    // Requests on an empty list, then a short list built by append and insert.
    send_request(ACT_READ, 6'd0, '0);
    send_request(ACT_ERASE, 6'd0, '0);
    send_request(ACT_INSERT, 6'd1, 64'h1111_2222_3333_4444);
    send_request(ACT_APPEND, 6'd0, '1);
    send_request(ACT_APPEND, 6'd0, '0);
    send_request(ACT_INSERT, 6'd0, 64'h0123_4567_89ab_cdef);
    send_request(ACT_INSERT, 6'd3, 64'hfedc_ba98_7654_3210);
    send_request(ACT_INSERT, 6'd5, 64'h5555_aaaa_5555_aaaa);
    for (n = 0; n < 5; n++) send_request(ACT_READ, FLD_W'(n), '1);
    send_request(ACT_READ, 6'd63, '0);
    send_request(ACT_ERASE, 6'd1, '0);
    send_request(ACT_ERASE, 6'd3, '0);
    for (n = ACT_BAD_FIRST; n <= ACT_BAD_LAST; n++) send_request(ACT_W'(n), 6'd0, '1);
    send_request(ACT_CLEAR, 6'd63, '1);
    send_request(ACT_READ, 6'd0, '0);

    for (phase = 0; phase < 10; phase++) begin
      drain_requests();
      repeat (RESULT_LATENCY) @(posedge clk);
      apb_write(REG_CAPACITY, 32'(caps[phase]));
      apb_check(REG_CAPACITY);
      if (phase == 1) long_hold_req = 1'b1;
      if (phase == 9) calm = 1'b1;
      for (n = 0; n < PHASE_ITEMS; n++) begin
        random_request();
        if (phase == 2 && n == PHASE_ITEMS / 2) drain_requests();
      end
    end

    drain_requests();
    repeat (RESULT_LATENCY * 4) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.expected_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
